@@ rtl/core/tun_pkg.sv @@
`default_nettype none
package tun_pkg;
  localparam int CW = 16;
  localparam int EW = CW + 1;
  localparam int PW = 2 * EW;
  localparam int CRW = PW + 1;
  localparam int MW = CRW;
  localparam int SQW = 2 * MW;
  localparam int SW = SQW + 2;
  localparam int RW = SW / 2;
  localparam int REMW = RW + 4;
  localparam int NF = 14;
  localparam int QW = NF + 1;
  localparam int DW = RW + 1;
  localparam int NUMW = MW + QW + 1;
  localparam int OW = 16;

  typedef struct packed {
    logic [2:0][MW-1:0] mag;
    logic [2:0] neg;
  } tun_side_t;

  typedef struct packed {
    logic [2:0][DW-1:0] rem;
    logic [2:0][QW-1:0] lo;
    logic [2:0][QW-1:0] quo;
    logic [2:0] neg;
    logic [DW-1:0] den;
    logic deg;
  } tun_div_t;
endpackage
`default_nettype wire

@@ rtl/core/tun_sqrt_cell.sv @@
`default_nettype none
module tun_sqrt_cell import tun_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            v_i,
  input  wire logic [REMW-1:0] rem_i,
  input  wire logic [RW-1:0]   root_i,
  input  wire logic [SW-1:0]   s_i,
  input  wire tun_side_t       side_i,
  output logic                 v_o,
  output logic [REMW-1:0]      rem_o,
  output logic [RW-1:0]        root_o,
  output logic [SW-1:0]        s_o,
  output tun_side_t            side_o
);
  logic            v_q;
  logic [REMW-1:0] rem_q, rem_d, r2, trial;
  logic [RW-1:0]   root_q, root_d;
  logic [SW-1:0]   s_q;
  tun_side_t       side_q;

  always_comb begin
    r2 = {rem_i[REMW-3:0], s_i[SW-1:SW-2]};
    trial = REMW'({root_i, 2'b01});
    if (r2 >= trial) begin
      rem_d = r2 - trial;
      root_d = {root_i[RW-2:0], 1'b1};
    end else begin
      rem_d = r2;
      root_d = {root_i[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      root_q <= root_d;
      s_q <= {s_i[SW-3:0], 2'b00};
      side_q <= side_i;
    end
  end

  assign v_o = v_q;
  assign rem_o = rem_q;
  assign root_o = root_q;
  assign s_o = s_q;
  assign side_o = side_q;
endmodule
`default_nettype wire

@@ rtl/core/tun_div_cell.sv @@
`default_nettype none
module tun_div_cell import tun_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     en_i,
  input  wire logic     v_i,
  input  wire tun_div_t d_i,
  output logic          v_o,
  output tun_div_t      d_o
);
  logic     v_q;
  tun_div_t d_q, d_d;
  logic [DW:0] r2;

  always_comb begin
    d_d = d_i;
    r2 = '0;
    for (int k = 0; k < 3; k++) begin
      r2 = {d_i.rem[k], d_i.lo[k][QW-1]};
      d_d.lo[k] = {d_i.lo[k][QW-2:0], 1'b0};
      if (r2 >= {1'b0, d_i.den}) begin
        d_d.rem[k] = DW'(r2 - {1'b0, d_i.den});
        d_d.quo[k] = {d_i.quo[k][QW-2:0], 1'b1};
      end else begin
        d_d.rem[k] = r2[DW-1:0];
        d_d.quo[k] = {d_i.quo[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign v_o = v_q;
  assign d_o = d_q;
endmodule
`default_nettype wire

@@ rtl/core/triangle_unit_normal_core.sv @@
// Channel  | Handshake               | Word
// input    | in_valid_i / in_ready_o | p0_*_i, p1_*_i, p2_*_i
// output   | out_valid_o / out_ready_i | normal_*_o, degenerate_o
// One triangle is taken in every cycle while the output side is not stalled.
// The pipeline is 5 front stages, 36 square-root cells, 15 divider cells and
// the output register.
// Reset clears only the valid bits of the pipeline.
// A result left waiting at the output holds the whole pipeline.
`default_nettype none
module triangle_unit_normal_core import tun_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [CW-1:0] p0_x_i,
  input  wire logic [CW-1:0] p0_y_i,
  input  wire logic [CW-1:0] p0_z_i,
  input  wire logic [CW-1:0] p1_x_i,
  input  wire logic [CW-1:0] p1_y_i,
  input  wire logic [CW-1:0] p1_z_i,
  input  wire logic [CW-1:0] p2_x_i,
  input  wire logic [CW-1:0] p2_y_i,
  input  wire logic [CW-1:0] p2_z_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [OW-1:0]      normal_x_o,
  output logic [OW-1:0]      normal_y_o,
  output logic [OW-1:0]      normal_z_o,
  output logic               degenerate_o
);
  logic en;
  logic [4:0] fv_q;
  logic signed [EW-1:0] a_q [3], b_q [3];
  logic signed [PW-1:0] pr_q [6];
  logic [MW-1:0] mag_q [3];
  logic [2:0] neg_q, neg2_q, neg3_q;
  logic [MW-1:0] mag2_q [3], mag3_q [3];
  logic [SQW-1:0] sq_q [3];
  logic [SW-1:0] sum_q;
  logic signed [CRW-1:0] cr [3];

  logic            sv [RW+1];
  logic [REMW-1:0] srem [RW+1];
  logic [RW-1:0]   sroot [RW+1];
  logic [SW-1:0]   ss [RW+1];
  tun_side_t       sside [RW+1];

  logic      dv [QW+1];
  tun_div_t  dd [QW+1];
  logic [NUMW-1:0] num [3];

  logic          out_valid_q;
  logic [OW-1:0] nx_q, ny_q, nz_q;
  logic          deg_q;
  logic [OW-1:0] res [3];

  assign en = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      fv_q <= {fv_q[3:0], in_valid_i};
      out_valid_q <= dv[QW];
    end
  end

  always_comb begin
    cr[0] = CRW'(pr_q[0]) - CRW'(pr_q[1]);
    cr[1] = CRW'(pr_q[2]) - CRW'(pr_q[3]);
    cr[2] = CRW'(pr_q[4]) - CRW'(pr_q[5]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q[0] <= $signed({p0_x_i[CW-1], p0_x_i}) - $signed({p1_x_i[CW-1], p1_x_i});
      a_q[1] <= $signed({p0_y_i[CW-1], p0_y_i}) - $signed({p1_y_i[CW-1], p1_y_i});
      a_q[2] <= $signed({p0_z_i[CW-1], p0_z_i}) - $signed({p1_z_i[CW-1], p1_z_i});
      b_q[0] <= $signed({p1_x_i[CW-1], p1_x_i}) - $signed({p2_x_i[CW-1], p2_x_i});
      b_q[1] <= $signed({p1_y_i[CW-1], p1_y_i}) - $signed({p2_y_i[CW-1], p2_y_i});
      b_q[2] <= $signed({p1_z_i[CW-1], p1_z_i}) - $signed({p2_z_i[CW-1], p2_z_i});
      pr_q[0] <= a_q[1] * b_q[2];
      pr_q[1] <= a_q[2] * b_q[1];
      pr_q[2] <= a_q[2] * b_q[0];
      pr_q[3] <= a_q[0] * b_q[2];
      pr_q[4] <= a_q[0] * b_q[1];
      pr_q[5] <= a_q[1] * b_q[0];
      for (int k = 0; k < 3; k++) begin
        neg_q[k] <= cr[k][CRW-1];
        mag_q[k] <= cr[k][CRW-1] ? MW'(-cr[k]) : MW'(cr[k]);
        sq_q[k] <= SQW'(mag_q[k]) * SQW'(mag_q[k]);
        mag2_q[k] <= mag_q[k];
        mag3_q[k] <= mag2_q[k];
      end
      neg2_q <= neg_q;
      neg3_q <= neg2_q;
      sum_q <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
    end
  end

  assign sv[0] = fv_q[4];
  assign srem[0] = '0;
  assign sroot[0] = '0;
  assign ss[0] = sum_q;
  assign sside[0].mag = {mag3_q[2], mag3_q[1], mag3_q[0]};
  assign sside[0].neg = neg3_q;

  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    tun_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .v_i    (sv[g]),
      .rem_i  (srem[g]),
      .root_i (sroot[g]),
      .s_i    (ss[g]),
      .side_i (sside[g]),
      .v_o    (sv[g+1]),
      .rem_o  (srem[g+1]),
      .root_o (sroot[g+1]),
      .s_o    (ss[g+1]),
      .side_o (sside[g+1])
    );
  end

  always_comb begin
    dd[0] = '0;
    dd[0].den = {sroot[RW][DW-2:0], 1'b0};
    dd[0].deg = (sroot[RW] == '0);
    dd[0].neg = sside[RW].neg;
    for (int k = 0; k < 3; k++) begin
      num[k] = {sside[RW].mag[k], {QW{1'b0}}} + NUMW'(sroot[RW]);
      dd[0].rem[k] = DW'(num[k][NUMW-1:QW]);
      dd[0].lo[k] = num[k][QW-1:0];
    end
  end
  assign dv[0] = sv[RW];

  for (genvar g = 0; g < QW; g++) begin : g_div
    tun_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .v_i    (dv[g]),
      .d_i    (dd[g]),
      .v_o    (dv[g+1]),
      .d_o    (dd[g+1])
    );
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dd[QW].deg) begin
        res[k] = '0;
      end else if (dd[QW].neg[k]) begin
        res[k] = OW'(-dd[QW].quo[k]);
      end else begin
        res[k] = OW'(dd[QW].quo[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= res[0];
      ny_q <= res[1];
      nz_q <= res[2];
      deg_q <= dd[QW].deg;
    end
  end

  assign out_valid_o = out_valid_q;
  assign normal_x_o = nx_q;
  assign normal_y_o = ny_q;
  assign normal_z_o = nz_q;
  assign degenerate_o = deg_q;
endmodule
`default_nettype wire

@@ rtl/core/tun_checker.sv @@
`default_nettype none
module tun_checker import tun_pkg::*; (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_ready_o,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire logic [OW-1:0] normal_x_o,
  input wire logic [OW-1:0] normal_y_o,
  input wire logic [OW-1:0] normal_z_o,
  input wire logic          degenerate_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(normal_x_o))
    else $error("result word changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");
  a_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
    else $error("degenerate word carries a normal");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(normal_x_o) <= 16384 && $signed(normal_x_o) >= -16384))
    else $error("normal x out of range");
endmodule

bind triangle_unit_normal_core tun_checker u_tun_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .normal_x_o   (normal_x_o),
  .normal_y_o   (normal_y_o),
  .normal_z_o   (normal_z_o),
  .degenerate_o (degenerate_o)
);
`default_nettype wire

@@ sim/triangle_unit_normal_core_tb.sv @@
module triangle_unit_normal_core_tb;
  import tun_pkg::*;

  typedef struct {
    logic [CW-1:0] p [9];
    bit            hold;
  } tri_t;

  typedef struct {
    logic [OW-1:0] nx, ny, nz;
    logic          deg;
  } normal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic [CW-1:0] pin [9];
  logic in_ready_o, out_valid_o, degenerate_o;
  logic [OW-1:0] normal_x_o, normal_y_o, normal_z_o;

  tri_t    tri_q [$];
  normal_t normal_q [$];
  int      errors = 0;
  int      n_out = 0;
  bit      in_took = 0, out_took = 0;
  int      send_gap = 0, recv_gap = 0;
  bit      stall_done = 0;

  initial for (int i = 0; i < 9; i++) pin[i] = '0;

  triangle_unit_normal_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .p0_x_i(pin[0]), .p0_y_i(pin[1]), .p0_z_i(pin[2]),
    .p1_x_i(pin[3]), .p1_y_i(pin[4]), .p1_z_i(pin[5]),
    .p2_x_i(pin[6]), .p2_y_i(pin[7]), .p2_z_i(pin[8]),
    .out_valid_o, .out_ready_i,
    .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );

  initial forever #5 clk_i = ~clk_i;

  function automatic normal_t face_normal(tri_t t);
    longint        v [9];
    longint        a [3], b [3], c [3];
    logic [127:0]  m [3];
    logic [127:0]  sum, sq, len, q;
    logic [63:0]   r, tt;
    normal_t       res;
    for (int i = 0; i < 9; i++) v[i] = longint'($signed(t.p[i]));
    for (int i = 0; i < 3; i++) begin
      a[i] = v[i] - v[3+i];
      b[i] = v[3+i] - v[6+i];
    end
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (c[i] < 0) ? 128'(-c[i]) : 128'(c[i]);
      sum += m[i] * m[i];
    end
    r = '0;
    for (int k = 40; k >= 0; k--) begin
      tt = r | (64'd1 << k);
      sq = 128'(tt) * 128'(tt);
      if (sq <= sum) r = tt;
    end
    len = 128'(r);
    res.deg = (len == 0);
    res.nx = '0;
    res.ny = '0;
    res.nz = '0;
    if (!res.deg) begin
      for (int i = 0; i < 3; i++) begin
        q = ((m[i] << (NF + 1)) + len) / (len << 1);
        if (c[i] < 0) q = -q;
        case (i)
          0: res.nx = q[OW-1:0];
          1: res.ny = q[OW-1:0];
          default: res.nz = q[OW-1:0];
        endcase
      end
    end
    return res;
  endfunction

  // The sender draws a fresh gap for every word, with stretches of none.
  function automatic int draw_gap(int count);
    return ((count / 150) % 3 == 1) ? 0 : $urandom_range(0, 15);
  endfunction

  always @(posedge clk_i) begin
    normal_t e;
    tri_t    t;
    in_took = in_valid_i && in_ready_o;
    out_took = out_valid_o && out_ready_i;
    if (in_took) begin
      for (int i = 0; i < 9; i++) t.p[i] = pin[i];
      normal_q.push_back(face_normal(t));
    end
    if (out_took) begin
      n_out++;
      if (normal_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = normal_q.pop_front();
        if (normal_x_o !== e.nx) begin
          $error("normal_x expected %h actual %h", e.nx, normal_x_o);
          errors++;
        end
        if (normal_y_o !== e.ny) begin
          $error("normal_y expected %h actual %h", e.ny, normal_y_o);
          errors++;
        end
        if (normal_z_o !== e.nz) begin
          $error("normal_z expected %h actual %h", e.nz, normal_z_o);
          errors++;
        end
        if (degenerate_o !== e.deg) begin
          $error("degenerate expected %b actual %b", e.deg, degenerate_o);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    tri_t t;
    if (rst_ni) begin
      if (in_valid_i && !in_took) begin
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (tri_q.size() > 0 && !(tri_q[0].hold && (normal_q.size() > 0 || in_took))) begin
        t = tri_q.pop_front();
        for (int i = 0; i < 9; i++) pin[i] <= t.p[i];
        in_valid_i <= 1'b1;
        send_gap = draw_gap(tri_q.size());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_took) begin
        if (n_out == 200 && !stall_done) begin
          recv_gap = 400;
          stall_done = 1;
        end else begin
          recv_gap = draw_gap(n_out + 75);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic add_tri(input int v [9], input bit hold = 0);
    tri_t t;
    for (int i = 0; i < 9; i++) t.p[i] = CW'(v[i]);
    t.hold = hold;
    tri_q.push_back(t);
  endtask

  initial begin
    int v [9];
    int base, k;
    add_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    add_tri('{256, 0, 0, 0, 0, 0, 0, 256, 0});
    add_tri('{0, 0, 0, 0, 256, 0, 0, 0, 256});
    add_tri('{0, 0, 0, 0, 0, 256, 256, 0, 0});
    add_tri('{0, 0, 0, 256, 256, 256, 512, 512, 512});
    add_tri('{32767, -32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768});
    add_tri('{-32768, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767});
    add_tri('{32767, 32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768});
    add_tri('{-32768, 32767, 0, 32767, -32768, 0, 0, 0, 32767});
    add_tri('{1, 0, 0, 0, 0, 0, 0, 1, 0});
    add_tri('{-1, -1, -1, 0, 0, 0, 1, 1, 1});
    add_tri('{5, 7, -3, 5, 7, -3, 100, -200, 50});
    add_tri('{3, 0, 0, 0, 0, 0, 0, 4, 0});
    add_tri('{-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767, 32767});
    add_tri('{1, 2, 3, 0, 0, 0, 0, 0, 1}, 1);
    for (int n = 0; n < 1000; n++) begin
      k = $urandom_range(0, 9);
      base = $urandom_range(0, 65535) - 32768;
      for (int i = 0; i < 9; i++) begin
        if (k < 5) v[i] = $urandom_range(0, 65535);
        else if (k < 8) v[i] = base + $urandom_range(0, 64) - 32;
        else v[i] = (i < 3) ? $urandom_range(0, 65535) : v[i-3];
      end
      if (k == 9) for (int i = 6; i < 9; i++) v[i] = 2 * v[i-3] - v[i-6];
      add_tri(v, n == 500);
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (tri_q.size() == 0 && !in_valid_i && normal_q.size() == 0);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && normal_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ triangle_unit_normal_core.f @@
rtl/core/tun_pkg.sv
rtl/core/tun_sqrt_cell.sv
rtl/core/tun_div_cell.sv
rtl/core/triangle_unit_normal_core.sv
rtl/core/tun_checker.sv
sim/triangle_unit_normal_core_tb.sv
